/* rtl/core/scw_pkg.sv */
// Shared types, constants and helpers for the spectral coherence window.
// No dependencies; every other file in rtl/core imports this package.
package scw_pkg;

    localparam int MAX_HALF_WIDTH = 512;
    localparam int STORE_DEPTH    = 2 * MAX_HALF_WIDTH;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int MAX_BINS       = 65536;
    localparam int CNT_W          = 17;
    localparam int HW_W           = 10;
    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 43;
    localparam int PWR_W          = 42;
    localparam int CHUNK_W        = 21;
    localparam int ACC_W          = 85;
    localparam int Q_W            = 16;
    localparam logic [HW_W-1:0] HALF_WIDTH_RESET = 10'd64;

    // Per-bin products of one stored bin
    typedef struct packed {
        logic [31:0]        px;
        logic [31:0]        pr;
        logic signed [32:0] cre;
        logic signed [32:0] cim;
    } bin_prod_t;

    // One result job handed from front to back
    typedef struct packed {
        logic [15:0]              index;
        logic signed [SUM_W-1:0]  cross_re;
        logic signed [SUM_W-1:0]  cross_im;
        logic [PWR_W-1:0]         meas_pwr;
        logic [PWR_W-1:0]         ref_pwr;
        logic                     last;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_RD,
        F_SUBP,
        F_SUBA,
        F_ADDA,
        F_EMIT
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_CHK,
        B_DIV,
        B_OUT
    } back_state_t;

    // Power and cross products of one measured/reference bin pair
    function automatic bin_prod_t bin_products(
        input logic signed [SAMPLE_W-1:0] xr,
        input logic signed [SAMPLE_W-1:0] xi,
        input logic signed [SAMPLE_W-1:0] rr,
        input logic signed [SAMPLE_W-1:0] ri
    );
        bin_prod_t          p;
        logic signed [31:0] sx1;
        logic signed [31:0] sx2;
        logic signed [31:0] sr1;
        logic signed [31:0] sr2;
        logic signed [32:0] t1;
        logic signed [32:0] t2;
        logic signed [32:0] t3;
        logic signed [32:0] t4;
        logic [32:0]        upx;
        logic [32:0]        upr;
        sx1 = xr * xr;
        sx2 = xi * xi;
        sr1 = rr * rr;
        sr2 = ri * ri;
        t1  = rr * xr;
        t2  = ri * xi;
        t3  = rr * xi;
        t4  = ri * xr;
        upx = {1'b0, sx1} + {1'b0, sx2};
        upr = {1'b0, sr1} + {1'b0, sr2};
        p.px  = upx[31:0];
        p.pr  = upr[31:0];
        p.cre = t1 + t2;
        p.cim = t3 - t4;
        return p;
    endfunction

endpackage

/* rtl/core/scw_front.sv */
// Front end: accepts bins and flush ticks, keeps the delay store and running sums.
// Depends on scw_pkg; pushes one job per result into the job queue.
module scw_front
    import scw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       command,
    input  logic signed [SAMPLE_W-1:0] meas_re,
    input  logic signed [SAMPLE_W-1:0] meas_im,
    input  logic signed [SAMPLE_W-1:0] ref_re,
    input  logic signed [SAMPLE_W-1:0] ref_im,
    input  logic                       final_bin,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [HW_W-1:0]            half_width,
    output job_t                       job,
    output logic                       job_push,
    input  logic                       job_full
);

    front_state_t state_reg, state_next;

    logic                       cmd_reg;
    logic                       final_reg;
    logic signed [SAMPLE_W-1:0] xr_reg, xi_reg, rr_reg, ri_reg;
    logic                       remove_reg;
    logic                       emit_reg;
    logic [HW_W-1:0]            hw_reg;
    logic [CNT_W-1:0]           ac_reg;
    logic [CNT_W-1:0]           ne_reg;
    logic                       ended_reg;
    logic [4*SAMPLE_W-1:0]      rd_data_reg;
    bin_prod_t                  prod_reg;
    logic signed [SUM_W-1:0]    mpwr_reg, rpwr_reg, cre_reg, cim_reg;

    logic [4*SAMPLE_W-1:0]      mem [STORE_DEPTH];

    logic [HW_W-1:0]            d;
    logic [CNT_W-1:0]           d_ext;
    logic                       accept;
    logic                       bin_ok;
    logic                       flush_ok;
    logic                       emitting;
    logic                       remove;
    logic [CNT_W-1:0]           rd_idx;
    logic                       last;
    logic signed [SUM_W-1:0]    px_ext, pr_ext, cre_ext, cim_ext;
    bin_prod_t                  rd_prod;
    bin_prod_t                  new_prod;

    // Saturate the half-width to 1..MAX_HALF_WIDTH
    always_comb
    begin
        if (hw_reg == '0)
            d = HW_W'(1);
        else if (hw_reg > HW_W'(MAX_HALF_WIDTH))
            d = HW_W'(MAX_HALF_WIDTH);
        else
            d = hw_reg;
    end

    assign d_ext    = CNT_W'(d);
    assign accept   = push && !full;
    assign bin_ok   = !command && !ended_reg;
    assign flush_ok = command && ended_reg && (ne_reg < ac_reg);
    assign emitting = (ac_reg + CNT_W'(1)) >= d_ext;
    assign remove   = ne_reg >= (d_ext + CNT_W'(1));
    assign rd_idx   = ne_reg - d_ext - CNT_W'(1);
    assign last     = ended_reg && ((ne_reg + CNT_W'(1)) == ac_reg);

    assign rd_prod  = bin_products(rd_data_reg[63:48], rd_data_reg[47:32],
                                   rd_data_reg[31:16], rd_data_reg[15:0]);
    assign new_prod = bin_products(xr_reg, xi_reg, rr_reg, ri_reg);

    assign px_ext  = $signed({11'b0, prod_reg.px});
    assign pr_ext  = $signed({11'b0, prod_reg.pr});
    assign cre_ext = {{(SUM_W-33){prod_reg.cre[32]}}, prod_reg.cre};
    assign cim_ext = {{(SUM_W-33){prod_reg.cim[32]}}, prod_reg.cim};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && (bin_ok || flush_ok))
                    state_next = F_RD;
            end
            F_RD:   state_next = F_SUBP;
            F_SUBP: state_next = F_SUBA;
            F_SUBA: state_next = cmd_reg ? F_EMIT : F_ADDA;
            F_ADDA: state_next = emit_reg ? F_EMIT : F_IDLE;
            F_EMIT:
            begin
                if (!job_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        full      = (state_reg != F_IDLE);
        cfg_ready = 1'b1;
        job_push  = (state_reg == F_EMIT) && !job_full;
        job.index    = ne_reg[15:0];
        job.cross_re = cre_reg;
        job.cross_im = cim_reg;
        job.meas_pwr = mpwr_reg[SUM_W-1] ? '0 : mpwr_reg[PWR_W-1:0];
        job.ref_pwr  = rpwr_reg[SUM_W-1] ? '0 : rpwr_reg[PWR_W-1:0];
        job.last     = last;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            hw_reg    <= HALF_WIDTH_RESET;
            ac_reg    <= '0;
            ne_reg    <= '0;
            ended_reg <= 1'b0;
            mpwr_reg  <= '0;
            rpwr_reg  <= '0;
            cre_reg   <= '0;
            cim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // Hold the half-width fixed within a set
            if (cfg_valid && cfg_ready && (ac_reg == '0) && !ended_reg)
                hw_reg <= half_width;
            // Drop the bin leaving the window
            if (state_reg == F_SUBA && remove_reg)
            begin
                mpwr_reg <= mpwr_reg - px_ext;
                rpwr_reg <= rpwr_reg - pr_ext;
                cre_reg  <= cre_reg - cre_ext;
                cim_reg  <= cim_reg - cim_ext;
            end
            // Add the new bin and advance the arrival count
            if (state_reg == F_ADDA)
            begin
                mpwr_reg <= mpwr_reg + px_ext;
                rpwr_reg <= rpwr_reg + pr_ext;
                cre_reg  <= cre_reg + cre_ext;
                cim_reg  <= cim_reg + cim_ext;
                ac_reg   <= ac_reg + CNT_W'(1);
                if (final_reg || ((ac_reg + CNT_W'(1)) >= CNT_W'(MAX_BINS)))
                    ended_reg <= 1'b1;
            end
            // Advance the emit index, clear the set after its last result
            if (job_push)
            begin
                if (last)
                begin
                    ac_reg    <= '0;
                    ne_reg    <= '0;
                    ended_reg <= 1'b0;
                    mpwr_reg  <= '0;
                    rpwr_reg  <= '0;
                    cre_reg   <= '0;
                    cim_reg   <= '0;
                end
                else
                begin
                    ne_reg <= ne_reg + CNT_W'(1);
                end
            end
        end
    end

    // Item capture and product pipeline
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && accept)
        begin
            cmd_reg    <= command;
            final_reg  <= final_bin;
            xr_reg     <= meas_re;
            xi_reg     <= meas_im;
            rr_reg     <= ref_re;
            ri_reg     <= ref_im;
            remove_reg <= bin_ok ? (emitting && remove) : remove;
            emit_reg   <= bin_ok ? emitting : 1'b1;
        end
        if (state_reg == F_SUBP)
            prod_reg <= rd_prod;
        if (state_reg == F_SUBA)
            prod_reg <= new_prod;
    end

    // Delay store: read the leaving bin first, then write the new one
    always_ff @(posedge clk)
    begin
        if (state_reg == F_RD)
            rd_data_reg <= mem[rd_idx[ADDR_W-1:0]];
        if (state_reg == F_SUBA && !cmd_reg)
            mem[ac_reg[ADDR_W-1:0]] <= {xr_reg, xi_reg, rr_reg, ri_reg};
    end

endmodule

/* rtl/core/scw_job_fifo.sv */
// Two-entry job queue between the front end and the divider back end.
// Depends on scw_pkg for job_t.
module scw_job_fifo
    import scw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rd_job = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en && !empty)
                rd_ptr_reg <= ~rd_ptr_reg;
            if ((wr_en && !full) && !(rd_en && !empty))
                count_reg <= count_reg + 2'd1;
            else if (!(wr_en && !full) && (rd_en && !empty))
                count_reg <= count_reg - 2'd1;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

/* rtl/core/scw_back.sv */
// Back end: squares the cross sums and multiplies the powers on a shared 21x21 multiplier, divides bit-serially.
// Depends on scw_pkg; takes jobs from the job queue, holds one result word.
module scw_back
    import scw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        in_job,
    input  logic        in_empty,
    output logic        in_pop,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] bin_index,
    output logic [15:0] coherence,
    output logic        invalid,
    output logic        last_out
);

    back_state_t state_reg, state_next;

    logic [PWR_W-1:0]     mre_reg, mim_reg, px_reg, pr_reg;
    logic [15:0]          idx_reg;
    logic                 last_reg;
    logic [3:0]           step_reg;
    logic [2*CHUNK_W-1:0] prod_reg;
    logic [1:0]           sh_reg;
    logic                 to_den_reg;
    logic [ACC_W-1:0]     num_reg, den_reg;
    logic [ACC_W:0]       rem_reg;
    logic [Q_W-1:0]       q_reg;
    logic                 inval_reg;
    logic [3:0]           cnt_reg;
    logic                 out_valid_reg;
    logic [15:0]          out_idx_reg, out_q_reg;
    logic                 out_inval_reg, out_last_reg;

    logic [1:0]           op;
    logic [PWR_W-1:0]     opa, opb;
    logic [CHUNK_W-1:0]   ca, cb;
    logic [ACC_W-1:0]     prod_sh;
    logic [ACC_W:0]       rem_sh;
    logic [ACC_W:0]       den_ext;
    logic                 out_free;
    logic [SUM_W-1:0]     abs_re, abs_im;

    assign abs_re = in_job.cross_re[SUM_W-1] ? -in_job.cross_re : in_job.cross_re;
    assign abs_im = in_job.cross_im[SUM_W-1] ? -in_job.cross_im : in_job.cross_im;

    // Operand and chunk select for the shared multiplier
    assign op = step_reg[3:2];
    always_comb
    begin
        unique case (op)
            2'd0:    begin opa = mre_reg; opb = mre_reg; end
            2'd1:    begin opa = mim_reg; opb = mim_reg; end
            default: begin opa = px_reg;  opb = pr_reg;  end
        endcase
        ca = step_reg[1] ? opa[2*CHUNK_W-1:CHUNK_W] : opa[CHUNK_W-1:0];
        cb = step_reg[0] ? opb[2*CHUNK_W-1:CHUNK_W] : opb[CHUNK_W-1:0];
    end

    always_comb
    begin
        unique case (sh_reg)
            2'd0:    prod_sh = ACC_W'(prod_reg);
            2'd1:    prod_sh = ACC_W'(prod_reg) << CHUNK_W;
            default: prod_sh = ACC_W'(prod_reg) << (2 * CHUNK_W);
        endcase
    end

    assign rem_sh   = {rem_reg[ACC_W-1:0], 1'b0};
    assign den_ext  = {1'b0, den_reg};
    assign out_free = !out_valid_reg || pop;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!in_empty) state_next = B_MUL;
            B_MUL:  if (step_reg == 4'd12) state_next = B_CHK;
            B_CHK:
            begin
                if (den_reg == '0 || num_reg >= den_reg)
                    state_next = B_OUT;
                else
                    state_next = B_DIV;
            end
            B_DIV:  if (cnt_reg == 4'd1) state_next = B_OUT;
            B_OUT:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_pop    = (state_reg == B_IDLE) && !in_empty;
        empty     = !out_valid_reg;
        bin_index = out_idx_reg;
        coherence = out_q_reg;
        invalid   = out_inval_reg;
        last_out  = out_last_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                mre_reg  <= abs_re[PWR_W-1:0];
                mim_reg  <= abs_im[PWR_W-1:0];
                px_reg   <= in_job.meas_pwr;
                pr_reg   <= in_job.ref_pwr;
                idx_reg  <= in_job.index;
                last_reg <= in_job.last;
                step_reg <= 4'd0;
                num_reg  <= '0;
                den_reg  <= '0;
            end
            B_MUL:
            begin
                // Multiply one chunk pair, accumulate the previous one
                prod_reg   <= ca * cb;
                sh_reg     <= 2'(step_reg[1]) + 2'(step_reg[0]);
                to_den_reg <= (op == 2'd2);
                step_reg   <= step_reg + 4'd1;
                if (step_reg != 4'd0)
                begin
                    if (to_den_reg)
                        den_reg <= den_reg + prod_sh;
                    else
                        num_reg <= num_reg + prod_sh;
                end
            end
            B_CHK:
            begin
                rem_reg   <= {1'b0, num_reg};
                cnt_reg   <= 4'd15;
                inval_reg <= (den_reg == '0);
                if (den_reg == '0)
                    q_reg <= '0;
                else if (num_reg >= den_reg)
                    q_reg <= Q_W'(32768);
                else
                    q_reg <= '0;
            end
            B_DIV:
            begin
                // One quotient bit per cycle
                if (rem_sh >= den_ext)
                begin
                    rem_reg <= rem_sh - den_ext;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 4'd1;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_idx_reg   <= idx_reg;
                    out_q_reg     <= q_reg;
                    out_inval_reg <= inval_reg;
                    out_last_reg  <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/core/spectral_coherence_window.sv */
// Top level of the sliding-window magnitude-squared coherence block.
// Depends on scw_pkg, scw_front, scw_job_fifo and scw_back.
//
//   channel   handshake            payload
//   input     push / full          command, meas_re/im, ref_re/im, final_bin
//   result    pop / empty          bin_index, coherence, invalid, last_out
//   config    cfg_valid/cfg_ready  half_width
//
// The front end takes one item at a time (store read, subtract, add, emit) and holds full
// until it is done. The back end runs each result through the shared 21x21 multiplier and
// then the bit-serial divider, which is skipped when the quotient is known; a two-entry job queue
// decouples the two, so the back end sets the rate once the queue has filled.
// Reset (rst_n low) clears the sums, counts and queues; half_width returns to 64.
// A result waits in the output register without stopping the next computation.
module spectral_coherence_window
    import scw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       command,
    input  logic signed [SAMPLE_W-1:0] meas_re,
    input  logic signed [SAMPLE_W-1:0] meas_im,
    input  logic signed [SAMPLE_W-1:0] ref_re,
    input  logic signed [SAMPLE_W-1:0] ref_im,
    input  logic                       final_bin,
    output logic                       empty,
    input  logic                       pop,
    output logic [15:0]                bin_index,
    output logic [15:0]                coherence,
    output logic                       invalid,
    output logic                       last_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [HW_W-1:0]            half_width
);

    job_t job_in, job_out;
    logic job_push, job_full, job_pop, job_empty;

    // Front end
    scw_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .meas_re   (meas_re),
        .meas_im   (meas_im),
        .ref_re    (ref_re),
        .ref_im    (ref_im),
        .final_bin (final_bin),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .half_width(half_width),
        .job       (job_in),
        .job_push  (job_push),
        .job_full  (job_full)
    );

    // Job queue
    scw_job_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (job_push),
        .wr_job(job_in),
        .full  (job_full),
        .rd_en (job_pop),
        .rd_job(job_out),
        .empty (job_empty)
    );

    // Back end
    scw_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_job   (job_out),
        .in_empty (job_empty),
        .in_pop   (job_pop),
        .empty    (empty),
        .pop      (pop),
        .bin_index(bin_index),
        .coherence(coherence),
        .invalid  (invalid),
        .last_out (last_out)
    );

endmodule
